### sv/assert_macros.svh
// Assertion macros used by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ede_pkg.sv
package ede_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // One input transfer.
  typedef struct packed {
    op_t        operation;
    logic [7:0] character;
  } cmd_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] distance;
    logic       reference_truncated;
  } res_t;

  // Token handed from one cell to the next. For a query byte, dnew is the
  // new column value of the left neighbor and dold its value one row earlier.
  // For an end token, dnew carries the distance toward the output.
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] chr;
    logic [7:0] dnew;
    logic [7:0] dold;
    logic       placed;
    logic       trunc;
  } tok_t;

endpackage

### sv/edit_distance_engine.sv
// Levenshtein distance engine. A command transfer is taken on every cycle in
// which start is high; busy is always low, so one command a cycle is the
// sustained rate. Each command travels as a token down a row of MAX_LEN
// cells, one cell per cycle, and each cell holds one reference byte and one
// entry of the distance column. The result of an end-query command appears
// on result with done high once its token has passed through all MAX_LEN
// cells of the row, whatever the reference length. Results come out in
// command order, at most one per cycle, and are shown for one cycle only:
// the receiver cannot stall and must take each transfer when done is high.
// Reference bytes beyond MAX_LEN are dropped and reported through
// reference_truncated; distances saturate at 255.
module edit_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ede_pkg::cmd_t command,
  output logic          done,
  output ede_pkg::res_t result
);

  `include "assert_macros.svh"

  localparam int LW = $clog2(MAX_LEN + 1);

  // Token bus between cells: entry k is the output of cell k, entry 0 the entry point.
  ede_pkg::tok_t tok [0:MAX_LEN];

  logic          accept;
  logic [7:0]    row;
  logic [7:0]    row_next;
  logic [7:0]    row_inc;
  logic [LW-1:0] ref_len;
  logic [LW-1:0] ref_len_next;
  logic          trunc;
  logic          trunc_next;

  // The row never holds off a command, since no cell ever stalls a token.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign row_inc = (row == 8'hFF) ? row : row + 8'd1;

  // Build the entry token and update the row index, reference length and
  // truncation flag. The column itself lives in the cells.
  always_comb begin
    row_next     = row;
    ref_len_next = ref_len;
    trunc_next   = trunc;
    tok[0].valid  = accept;
    tok[0].op     = command.operation;
    tok[0].chr    = command.character;
    tok[0].dnew   = row;
    tok[0].dold   = row;
    tok[0].placed = 1'b0;
    tok[0].trunc  = trunc;
    if (accept) begin
      case (command.operation)
        ede_pkg::OP_CLEAR: begin
          row_next     = 8'd0;
          ref_len_next = '0;
          trunc_next   = 1'b0;
        end
        ede_pkg::OP_APPEND: begin
          row_next = 8'd0;
          if (ref_len == LW'(MAX_LEN)) begin
            trunc_next = 1'b1;
          end else begin
            ref_len_next = ref_len + LW'(1);
          end
        end
        ede_pkg::OP_QUERY: begin
          // Column entry zero is the row index itself.
          tok[0].dnew = row_inc;
          row_next    = row_inc;
        end
        ede_pkg::OP_END: begin
          // With an empty reference the distance is the query length.
          row_next = 8'd0;
        end
        default: begin
          row_next = row;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= 8'd0;
      ref_len <= '0;
      trunc   <= 1'b0;
    end else begin
      row     <= row_next;
      ref_len <= ref_len_next;
      trunc   <= trunc_next;
    end
  end

  // Cell k holds reference byte k-1 and column entry k.
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ede_cell #(
      .J(k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .tin  (tok[k-1]),
      .tout (tok[k])
    );
  end

  // An end token leaving the last cell carries the distance of the whole reference.
  assign done                       = tok[MAX_LEN].valid && (tok[MAX_LEN].op == ede_pkg::OP_END);
  assign result.distance            = tok[MAX_LEN].dnew;
  assign result.reference_truncated = tok[MAX_LEN].trunc;

  `ASSERT_CLK(a_len_bound, ref_len <= LW'(MAX_LEN), "reference length beyond MAX_LEN")
  `ASSERT_CLK(a_done_from_end,
    !done || $past(accept && command.operation == ede_pkg::OP_END, MAX_LEN),
    "result without an end command MAX_LEN cycles earlier")
  `ASSERT_NEXT(a_clear_state, accept && command.operation == ede_pkg::OP_CLEAR,
    row == 8'd0 && ref_len == '0 && !trunc, "clear did not reset the engine state")
  `ASSERT_NEXT(a_trunc_set,
    accept && command.operation == ede_pkg::OP_APPEND && ref_len == LW'(MAX_LEN),
    trunc, "append to a full reference did not set the truncation flag")

endmodule

### sv/ede_cell.sv
module ede_cell #(
  parameter int J = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  ede_pkg::tok_t tin,
  output ede_pkg::tok_t tout
);

  logic          active;
  logic          active_next;
  logic [7:0]    refb;
  logic [7:0]    refb_next;
  logic [7:0]    d;
  logic [7:0]    d_next;
  ede_pkg::tok_t tout_next;

  logic [8:0] sub;
  logic [8:0] del;
  logic [8:0] ins;
  logic [8:0] m;

  // One step of the recurrence: diagonal plus mismatch, above plus one, left plus one.
  always_comb begin
    sub = {1'b0, tin.dold} + {8'd0, (refb != tin.chr)};
    del = {1'b0, d} + 9'd1;
    ins = {1'b0, tin.dnew} + 9'd1;
    m   = (sub < del) ? sub : del;
    if (ins < m) begin
      m = ins;
    end
  end

  always_comb begin
    active_next = active;
    refb_next   = refb;
    d_next      = d;
    tout_next   = tin;
    if (tin.valid) begin
      case (tin.op)
        ede_pkg::OP_CLEAR: begin
          active_next = 1'b0;
          d_next      = 8'(J);
        end
        ede_pkg::OP_APPEND: begin
          // The first empty cell takes the byte.
          if (!active && !tin.placed) begin
            active_next      = 1'b1;
            refb_next        = tin.chr;
            tout_next.placed = 1'b1;
          end
          d_next = 8'(J);
        end
        ede_pkg::OP_QUERY: begin
          if (active) begin
            d_next         = m[8] ? 8'hFF : m[7:0];
            tout_next.dnew = d_next;
            tout_next.dold = d;
          end
        end
        ede_pkg::OP_END: begin
          if (active) begin
            tout_next.dnew = d;
          end
          d_next = 8'(J);
        end
        default: begin
          tout_next = tin;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      d          <= 8'(J);
      tout.valid <= 1'b0;
    end else begin
      active     <= active_next;
      d          <= d_next;
      tout.valid <= tout_next.valid;
    end
    refb        <= refb_next;
    tout.op     <= tout_next.op;
    tout.chr    <= tout_next.chr;
    tout.dnew   <= tout_next.dnew;
    tout.dold   <= tout_next.dold;
    tout.placed <= tout_next.placed;
    tout.trunc  <= tout_next.trunc;
  end

endmodule
